// File: hdl/wspd_pkg.sv
`timescale 1ns / 1ps

package wspd_pkg;

  // Default build values
  localparam int PACKET_BYTES_DEF  = 24;
  localparam int MAX_DATA_SETS_DEF = 5;

  // CRC-8, MSB first, zero start value, no final xor
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Start nibbles of the two frame formats
  localparam logic [3:0] START_SHORT = 4'h9;
  localparam logic [3:0] START_MULTI = 4'hA;

  // Data set types of the multi-set format
  localparam logic [3:0] SET_TEMP  = 4'h0;
  localparam logic [3:0] SET_HUMID = 4'h1;
  localparam logic [3:0] SET_RAIN  = 4'h2;
  localparam logic [3:0] SET_WIND  = 4'h3;
  localparam logic [3:0] SET_GUST  = 4'h4;

  // Offset of the decimal temperature, in tenths of a degree
  localparam logic [11:0] TEMP_OFFSET = 12'd400;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CRC_FAULT = 2'd1,
    ST_BAD_START = 2'd2,
    ST_TOO_MANY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FRAME_NONE  = 2'd0,
    FRAME_SHORT = 2'd1,
    FRAME_MULTI = 2'd2
  } frame_kind_t;

  // One decoded packet as it leaves the block
  typedef struct packed {
    status_t            status;
    logic [7:0]         sensor_id;
    logic [4:0]         present_mask;
    logic               battery_new;
    logic               battery_weak;
    logic               sensor_error;
    logic signed [11:0] temp_tenths;
    logic [7:0]         humidity;
    logic [11:0]        rain_count;
    logic [3:0]         wind_direction;
    logic [7:0]         wind_speed;
    logic [11:0]        wind_gust;
  } result_t;

  // Advance the CRC by one byte, eight bit steps
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    c = crc_in;
    d = b;
    for (int i = 0; i < 8; i++) begin
      if (c[7] ^ d[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
      d = {d[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: hdl/weather_sensor_packet_decoder.sv
`timescale 1ns / 1ps

// Weather sensor packet decoder.
// Input channel: one received byte per transfer (data_byte), with packet_start
// high on the first byte of a packet. The CRC-8 (poly 0x31) and all field
// capture for a byte are done in the cycle of its transfer, so one byte is
// taken every cycle while in_stall is low; the unrolled CRC byte update
// sets the path length. Output channel: one result per packet, produced by
// the CRC byte or by the byte that rejects the packet (byte 0 for an unknown
// start nibble, byte 1 for too many data sets). The result is registered,
// or parked in the skid register while the output is held. Bytes outside a
// packet and a packet cut short by a new packet_start give no result.
// Stall handling: a result register plus one skid register sit on the output.
// Input bytes keep flowing while a result waits; in_stall rises only when a
// second result is held in the skid register, and drops once it moves on.
// Reset (rst, synchronous) empties both output registers and leaves the
// decoder idle until the next packet_start.
module weather_sensor_packet_decoder
  import wspd_pkg::*;
#(
  parameter int PACKET_BYTES  = PACKET_BYTES_DEF,
  parameter int MAX_DATA_SETS = MAX_DATA_SETS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               packet_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [7:0]         sensor_id,
  output logic [4:0]         present_mask,
  output logic               battery_new,
  output logic               battery_weak,
  output logic               sensor_error,
  output logic signed [11:0] temp_tenths,
  output logic [7:0]         humidity,
  output logic [11:0]        rain_count,
  output logic [3:0]         wind_direction,
  output logic [7:0]         wind_speed,
  output logic [11:0]        wind_gust
);

  localparam int CW = $clog2(MAX_DATA_SETS + 1);
  localparam int PW = $clog2(2 * MAX_DATA_SETS + 3);

  // Packet state
  logic              done, done_next;
  frame_kind_t       kind, kind_next;
  logic [PW-1:0]     pos, pos_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [7:0]        head, head_next;
  logic [7:0]        crc, crc_next;
  logic [7:0]        id, id_next;
  logic              bnew, bnew_next;
  logic              bweak, bweak_next;
  logic              berr, berr_next;
  logic [10:0]       traw, traw_next;
  logic [7:0]        hum, hum_next;
  logic [11:0]       rain, rain_next;
  logic [3:0]        wdir, wdir_next;
  logic [7:0]        wspd, wspd_next;
  logic [11:0]       gust, gust_next;
  logic [4:0]        mask, mask_next;

  // Output side
  result_t           out_r;
  result_t           skid;
  logic              skid_valid;

  logic              take;
  logic              res_valid;
  status_t           res_status;
  result_t           res;
  logic [PW-1:0]     p;
  logic [PW-1:0]     crc_idx;
  logic [3:0]        n;
  logic [7:0]        crc_upd;
  logic              ok;

  assign take     = in_valid && !in_stall;
  assign in_stall = skid_valid;
  // A new packet folds its first byte into a zero CRC
  assign crc_upd  = crc8_byte(packet_start ? 8'h00 : crc, data_byte);
  assign n        = data_byte[3:0];

  // Decode one byte
  always_comb begin
    done_next  = done;
    kind_next  = kind;
    pos_next   = pos;
    cnt_next   = cnt;
    head_next  = head;
    crc_next   = crc;
    id_next    = id;
    bnew_next  = bnew;
    bweak_next = bweak;
    berr_next  = berr;
    traw_next  = traw;
    hum_next   = hum;
    rain_next  = rain;
    wdir_next  = wdir;
    wspd_next  = wspd;
    gust_next  = gust;
    mask_next  = mask;
    res_valid  = 1'b0;
    res_status = ST_OK;
    p          = pos;
    crc_idx    = PW'({cnt, 1'b0}) + PW'(2);

    if (take && (packet_start || !done)) begin
      // A new packet drops whatever was in progress
      if (packet_start) begin
        done_next  = 1'b0;
        kind_next  = FRAME_NONE;
        pos_next   = '0;
        cnt_next   = '0;
        head_next  = '0;
        crc_next   = '0;
        id_next    = '0;
        bnew_next  = 1'b0;
        bweak_next = 1'b0;
        berr_next  = 1'b0;
        traw_next  = '0;
        hum_next   = '0;
        rain_next  = '0;
        wdir_next  = '0;
        wspd_next  = '0;
        gust_next  = '0;
        mask_next  = '0;
        p          = '0;
        crc_idx    = PW'(2);
      end

      if (p == PW'(0)) begin
        // Start nibble selects the frame format
        if (data_byte[7:4] == START_SHORT || data_byte[7:4] == START_MULTI) begin
          kind_next = (data_byte[7:4] == START_SHORT) ? FRAME_SHORT : FRAME_MULTI;
          id_next   = {data_byte[3:0], 4'b0000};
          crc_next  = crc_upd;
          pos_next  = PW'(1);
        end else begin
          res_valid  = 1'b1;
          res_status = ST_BAD_START;
          done_next  = 1'b1;
        end
      end else if (p == PW'(1)) begin
        id_next[3:2] = data_byte[7:6];
        bnew_next    = data_byte[5];
        if (kind == FRAME_SHORT) begin
          traw_next = 11'(data_byte[3:0]) * 11'd100;
          crc_next  = crc_upd;
          pos_next  = PW'(2);
        end else begin
          berr_next = data_byte[4];
          if ((32'(n) > MAX_DATA_SETS) || (32'(n) * 2 + 2 >= PACKET_BYTES)) begin
            res_valid  = 1'b1;
            res_status = ST_TOO_MANY;
            done_next  = 1'b1;
          end else begin
            cnt_next = CW'(n);
            crc_next = crc_upd;
            pos_next = PW'(2);
          end
        end
      end else if (kind == FRAME_SHORT) begin
        if (p < PW'(4)) begin
          if (p == PW'(2)) begin
            traw_next = traw + 11'(data_byte[7:4]) * 11'd10 + 11'(data_byte[3:0]);
          end else begin
            bweak_next = data_byte[7];
            hum_next   = {1'b0, data_byte[6:0]};
            mask_next  = 5'b00011;
          end
          crc_next = crc_upd;
          pos_next = p + PW'(1);
        end else begin
          res_valid  = 1'b1;
          res_status = (crc == data_byte) ? ST_OK : ST_CRC_FAULT;
          done_next  = 1'b1;
        end
      end else begin
        if (p < crc_idx) begin
          // Even byte holds the set head, odd byte completes the set
          if (!p[0]) begin
            head_next = data_byte;
          end else begin
            unique case (head[7:4])
              SET_TEMP: begin
                traw_next    = 11'(head[3:0]) * 11'd100 + 11'(data_byte[7:4]) * 11'd10
                               + 11'(data_byte[3:0]);
                mask_next[0] = 1'b1;
              end
              SET_HUMID: begin
                hum_next     = 8'(data_byte[7:4]) * 8'd10 + 8'(data_byte[3:0]);
                mask_next[1] = 1'b1;
              end
              SET_RAIN: begin
                rain_next    = {head[3:0], data_byte};
                mask_next[2] = 1'b1;
              end
              SET_WIND: begin
                wdir_next    = head[3:0];
                wspd_next    = data_byte;
                mask_next[3] = 1'b1;
              end
              SET_GUST: begin
                gust_next    = {head[3:0], data_byte};
                mask_next[4] = 1'b1;
              end
              default: begin
              end
            endcase
          end
          crc_next = crc_upd;
          pos_next = p + PW'(1);
        end else begin
          res_valid  = 1'b1;
          res_status = (crc == data_byte) ? ST_OK : ST_CRC_FAULT;
          done_next  = 1'b1;
        end
      end
    end
  end

  // Assemble the result; a rejected packet reports zeros
  assign ok = (res_status == ST_OK);

  always_comb begin
    res                = '0;
    res.status         = res_status;
    if (ok) begin
      res.sensor_id      = id_next;
      res.present_mask   = mask_next;
      res.battery_new    = bnew_next;
      res.battery_weak   = bweak_next;
      res.sensor_error   = berr_next;
      res.temp_tenths    = mask_next[0] ? $signed(12'(traw_next) - TEMP_OFFSET) : '0;
      res.humidity       = mask_next[1] ? hum_next : '0;
      res.rain_count     = mask_next[2] ? rain_next : '0;
      res.wind_direction = mask_next[3] ? wdir_next : '0;
      res.wind_speed     = mask_next[3] ? wspd_next : '0;
      res.wind_gust      = mask_next[4] ? gust_next : '0;
    end
  end

  // Hold packet state
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b1;
      kind <= FRAME_NONE;
      pos  <= '0;
      cnt  <= '0;
      crc  <= '0;
    end else begin
      done <= done_next;
      kind <= kind_next;
      pos  <= pos_next;
      cnt  <= cnt_next;
      crc  <= crc_next;
    end
    head  <= head_next;
    id    <= id_next;
    bnew  <= bnew_next;
    bweak <= bweak_next;
    berr  <= berr_next;
    traw  <= traw_next;
    hum   <= hum_next;
    rain  <= rain_next;
    wdir  <= wdir_next;
    wspd  <= wspd_next;
    gust  <= gust_next;
    mask  <= mask_next;
  end

  // Result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      // Output free: drain skid first, else load a fresh result
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_r      <= skid;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
        if (res_valid) begin
          out_r <= res;
        end
      end
    end else if (res_valid) begin
      // Output held: park the new result
      skid_valid <= 1'b1;
      skid       <= res;
    end
  end

  assign status         = out_r.status;
  assign sensor_id      = out_r.sensor_id;
  assign present_mask   = out_r.present_mask;
  assign battery_new    = out_r.battery_new;
  assign battery_weak   = out_r.battery_weak;
  assign sensor_error   = out_r.sensor_error;
  assign temp_tenths    = out_r.temp_tenths;
  assign humidity       = out_r.humidity;
  assign rain_count     = out_r.rain_count;
  assign wind_direction = out_r.wind_direction;
  assign wind_speed     = out_r.wind_speed;
  assign wind_gust      = out_r.wind_gust;

endmodule

// File: dv/weather_sensor_packet_decoder_tb.sv
`timescale 1ns / 1ps

module weather_sensor_packet_decoder_tb
  import wspd_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 150;
  localparam int TAIL_CYCLES    = 20;

  logic clk          = 1'b0;
  logic rst          = 1'b1;
  logic in_valid     = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic packet_start = 1'b0;
  logic out_stall    = 1'b0;

  logic               in_stall;
  logic               out_valid;
  logic [1:0]         status;
  logic [7:0]         sensor_id;
  logic [4:0]         present_mask;
  logic               battery_new;
  logic               battery_weak;
  logic               sensor_error;
  logic signed [11:0] temp_tenths;
  logic [7:0]         humidity;
  logic [11:0]        rain_count;
  logic [3:0]         wind_direction;
  logic [7:0]         wind_speed;
  logic [11:0]        wind_gust;

  weather_sensor_packet_decoder u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .packet_start   (packet_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .sensor_id      (sensor_id),
    .present_mask   (present_mask),
    .battery_new    (battery_new),
    .battery_weak   (battery_weak),
    .sensor_error   (sensor_error),
    .temp_tenths    (temp_tenths),
    .humidity       (humidity),
    .rain_count     (rain_count),
    .wind_direction (wind_direction),
    .wind_speed     (wind_speed),
    .wind_gust      (wind_gust)
  );

  // Decoded packets still owed by the block, oldest first
  result_t expected_packets[$];
  result_t oldest;
  int mismatches = 0;
  int bytes_sent = 0;

  // Idle and stall rates of the two sides, in percent
  int tx_idle_pct  = 7;
  int rx_stall_pct = 59;

  // Long receiver hold-off, requested by a test, counted by the receiver
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  int quiet_cycles = 0;

  // Packet decoder state as the testbench sees it
  logic [4:0]  pk_pos      = '0;
  logic [7:0]  pk_crc      = '0;
  frame_kind_t pk_kind     = FRAME_NONE;
  logic [3:0]  pk_sets     = '0;
  logic [7:0]  pk_head     = '0;
  logic        pk_closed   = 1'b1;
  result_t     pk_fields   = '0;
  logic [10:0] pk_temp_raw = '0;

  // Bytes of the packet being built for sending
  logic [7:0] frame_bytes[$];

  initial begin
    forever #1 clk = ~clk;
  end

  // CRC-8, poly 0x31, MSB first: fold the byte in, then shift eight times
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
    return r;
  endfunction

  // Any first byte whose start nibble is neither format
  function automatic logic [7:0] bad_start_byte();
    int nib;
    nib = $urandom_range(0, 13);
    if (nib >= 9) nib += 2;
    return {4'(nib), 4'($urandom)};
  endfunction

  // Finish the packet: build the result and mark the decoder idle
  task automatic close_packet(input status_t st);
    result_t r;
    logic [4:0] m;
    r = '0;
    m = pk_fields.present_mask;
    r.status = st;
    if (st == ST_OK) begin
      r.sensor_id    = pk_fields.sensor_id;
      r.present_mask = m;
      r.battery_new  = pk_fields.battery_new;
      r.battery_weak = pk_fields.battery_weak;
      r.sensor_error = pk_fields.sensor_error;
      if (m[0]) r.temp_tenths = 12'(pk_temp_raw) - TEMP_OFFSET;
      if (m[1]) r.humidity = pk_fields.humidity;
      if (m[2]) r.rain_count = pk_fields.rain_count;
      if (m[3]) begin
        r.wind_direction = pk_fields.wind_direction;
        r.wind_speed     = pk_fields.wind_speed;
      end
      if (m[4]) r.wind_gust = pk_fields.wind_gust;
    end
    expected_packets.push_back(r);
    pk_closed = 1'b1;
  endtask

  // Capture one two-byte data set of the multi-set format
  task automatic apply_set(input logic [7:0] h, input logic [7:0] d);
    case (h[7:4])
      SET_TEMP: begin
        pk_temp_raw = 11'(100 * h[3:0] + 10 * d[7:4] + d[3:0]);
        pk_fields.present_mask[0] = 1'b1;
      end
      SET_HUMID: begin
        pk_fields.humidity = 8'(10 * d[7:4] + d[3:0]);
        pk_fields.present_mask[1] = 1'b1;
      end
      SET_RAIN: begin
        pk_fields.rain_count = {h[3:0], d};
        pk_fields.present_mask[2] = 1'b1;
      end
      SET_WIND: begin
        pk_fields.wind_direction = h[3:0];
        pk_fields.wind_speed     = d;
        pk_fields.present_mask[3] = 1'b1;
      end
      SET_GUST: begin
        pk_fields.wind_gust = {h[3:0], d};
        pk_fields.present_mask[4] = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Advance the decoder by one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic opens_packet);
    int crc_at;
    if (opens_packet) begin
      pk_pos      = '0;
      pk_crc      = '0;
      pk_kind     = FRAME_NONE;
      pk_sets     = '0;
      pk_head     = '0;
      pk_fields   = '0;
      pk_temp_raw = '0;
      pk_closed   = 1'b0;
    end else if (pk_closed) begin
      return;
    end
    if (pk_pos == 0) begin
      if (b[7:4] == START_SHORT) begin
        pk_kind = FRAME_SHORT;
      end else if (b[7:4] == START_MULTI) begin
        pk_kind = FRAME_MULTI;
      end else begin
        close_packet(ST_BAD_START);
        return;
      end
      pk_fields.sensor_id = {b[3:0], 4'h0};
      pk_crc = crc8_next(pk_crc, b);
      pk_pos = 5'd1;
    end else if (pk_pos == 1) begin
      pk_fields.sensor_id[3:2] = b[7:6];
      pk_fields.battery_new    = b[5];
      if (pk_kind == FRAME_SHORT) begin
        pk_temp_raw = 11'(100 * b[3:0]);
      end else begin
        pk_fields.sensor_error = b[4];
        if (b[3:0] > MAX_DATA_SETS_DEF || 2 + 2 * b[3:0] >= PACKET_BYTES_DEF) begin
          close_packet(ST_TOO_MANY);
          return;
        end
        pk_sets = b[3:0];
      end
      pk_crc = crc8_next(pk_crc, b);
      pk_pos = 5'd2;
    end else if (pk_kind == FRAME_SHORT) begin
      if (pk_pos == 4) begin
        close_packet(pk_crc == b ? ST_OK : ST_CRC_FAULT);
      end else begin
        if (pk_pos == 2) begin
          pk_temp_raw = 11'(pk_temp_raw + 10 * b[7:4] + b[3:0]);
        end else begin
          pk_fields.battery_weak = b[7];
          pk_fields.humidity     = {1'b0, b[6:0]};
          pk_fields.present_mask = 5'b00011;
        end
        pk_crc = crc8_next(pk_crc, b);
        pk_pos = pk_pos + 5'd1;
      end
    end else begin
      crc_at = 2 + 2 * pk_sets;
      if (pk_pos < crc_at) begin
        if (!pk_pos[0]) pk_head = b;
        else apply_set(pk_head, b);
        pk_crc = crc8_next(pk_crc, b);
        pk_pos = pk_pos + 5'd1;
      end else begin
        close_packet(pk_crc == b ? ST_OK : ST_CRC_FAULT);
      end
    end
  endtask

  // Offer one byte, hold it until the transfer, then predict
  task automatic send_byte(input logic [7:0] b, input logic opens_packet);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    packet_start <= opens_packet;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, opens_packet);
    bytes_sent++;
  endtask

  // Append the CRC (optionally wrong) and send the first keep bytes, or all
  task automatic send_frame(input bit corrupt, input int keep);
    logic [7:0] crc;
    int count;
    crc = '0;
    foreach (frame_bytes[i]) crc = crc8_next(crc, frame_bytes[i]);
    if (corrupt) crc ^= 8'($urandom_range(1, 255));
    frame_bytes.push_back(crc);
    count = (keep > 0 && keep < frame_bytes.size()) ? keep : frame_bytes.size();
    for (int i = 0; i < count; i++) send_byte(frame_bytes[i], i == 0);
    frame_bytes.delete();
  endtask

  task automatic queue_short_frame();
    frame_bytes.push_back({START_SHORT, 4'($urandom)});
    repeat (3) frame_bytes.push_back(8'($urandom));
  endtask

  // Mostly known set types, now and then an unknown one
  task automatic queue_multi_frame(input int nsets);
    int set_type;
    frame_bytes.push_back({START_MULTI, 4'($urandom)});
    frame_bytes.push_back({4'($urandom), 4'(nsets)});
    repeat (nsets) begin
      set_type = ($urandom_range(7) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 4);
      frame_bytes.push_back({4'(set_type), 4'($urandom)});
      frame_bytes.push_back(8'($urandom));
    end
  endtask

  // Mostly well-formed packets; the rest rejected, cut short or stray
  task automatic send_random_packet();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      queue_multi_frame($urandom_range(0, MAX_DATA_SETS_DEF));
      send_frame($urandom_range(9) == 0, 0);
    end else if (pick < 70) begin
      queue_short_frame();
      send_frame($urandom_range(9) == 0, 0);
    end else if (pick < 78) begin
      frame_bytes.push_back(bad_start_byte());
      send_frame(1'b0, 1);
    end else if (pick < 86) begin
      queue_multi_frame(0);
      frame_bytes[1][3:0] = 4'($urandom_range(MAX_DATA_SETS_DEF + 1, 15));
      send_frame(1'b0, 2);
    end else if (pick < 94) begin
      if (pick[0]) queue_short_frame();
      else queue_multi_frame($urandom_range(0, MAX_DATA_SETS_DEF));
      send_frame(1'b0, $urandom_range(1, frame_bytes.size()));
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    end
    if ($urandom_range(9) == 0) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic test_bad_start();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  // Too many data sets, then a trailing byte that must be ignored
  task automatic test_too_many_sets();
    frame_bytes = '{8'hAF, 8'hF6};
    send_frame(1'b0, 0);
  endtask

  // Highest and lowest temperature of the fixed frame
  task automatic test_short_frame();
    frame_bytes = '{8'h9F, 8'hFF, 8'hFF, 8'hFF};
    send_frame(1'b0, 0);
    frame_bytes = '{8'h90, 8'h00, 8'h00, 8'h00};
    send_frame(1'b0, 0);
  endtask

  // Cut packet, zero sets with a CRC fault, five sets with overwrite and unknown type
  task automatic test_multi_frame();
    frame_bytes = '{8'hA5, 8'h32, 8'h00, 8'h00};
    send_frame(1'b0, 2);
    frame_bytes = '{8'hA0, 8'h30};
    send_frame(1'b1, 0);
    frame_bytes = '{8'hAF, 8'hF5, 8'h00, 8'h00, 8'hF5, 8'h5A,
                    8'h1F, 8'hFF, 8'h0F, 8'hFF, 8'h3F, 8'hFF};
    send_frame(1'b0, 0);
  endtask

  // Hold the receiver off while rejected packets keep coming
  task automatic test_backpressure();
    hold_requests++;
    repeat (40) send_byte(bad_start_byte(), 1'b1);
  endtask

  // Stop sending until every owed result has come out
  task automatic test_pause_until_drained();
    repeat (3) begin
      repeat (8) send_random_packet();
      in_valid <= 1'b0;
      do @(posedge clk); while (expected_packets.size() != 0);
    end
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
    int target;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    target = bytes_sent + count;
    while (bytes_sent < target) send_random_packet();
  endtask

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // Receiver: random stall, or a long hold when one is requested
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Compare each result transfer with the oldest owed packet
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_packets.size() == 0) begin
        $display("%0t: result with none owed: expected nothing, actual status %0d",
                 $time, status);
        mismatches++;
      end else begin
        oldest = expected_packets.pop_front();
        check_field("status", oldest.status, status);
        check_field("sensor_id", oldest.sensor_id, sensor_id);
        check_field("present_mask", oldest.present_mask, present_mask);
        check_field("battery_new", oldest.battery_new, battery_new);
        check_field("battery_weak", oldest.battery_weak, battery_weak);
        check_field("sensor_error", oldest.sensor_error, sensor_error);
        check_field("temp_tenths", int'(oldest.temp_tenths), int'(temp_tenths));
        check_field("humidity", oldest.humidity, humidity);
        check_field("rain_count", oldest.rain_count, rain_count);
        check_field("wind_direction", oldest.wind_direction, wind_direction);
        check_field("wind_speed", oldest.wind_speed, wind_speed);
        check_field("wind_gust", oldest.wind_gust, wind_gust);
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("weather_sensor_packet_decoder_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_bad_start();
    test_too_many_sets();
    test_short_frame();
    test_multi_frame();
    test_backpressure();
    test_random_traffic(7, 59, 420);
    test_random_traffic(59, 7, 420);
    test_pause_until_drained();
    test_random_traffic(0, 0, 420);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_packets.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("weather_sensor_packet_decoder_tb: clean");
    end else begin
      $display("weather_sensor_packet_decoder_tb: errors");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/wspd_pkg.sv
hdl/weather_sensor_packet_decoder.sv
dv/weather_sensor_packet_decoder_tb.sv
